// File: rtl/core/ialu_pkg.sv
package ialu_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned REG_IDX_W = 5;
    localparam int unsigned OP3_W     = 6;
    localparam int unsigned SIMM_W    = 13;
    localparam int unsigned IMM22_W   = 22;
    localparam int unsigned SHAMT_W   = 5;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [OP3_W-1:0]     op3_t;
    typedef logic [1:0]           op_t;

    // instruction format codes
    localparam op_t OP_SETHI = 2'd0;
    localparam op_t OP_ARITH = 2'd2;

    // format-3 operation codes
    localparam op3_t OP3_ADD  = 6'h00;
    localparam op3_t OP3_AND  = 6'h01;
    localparam op3_t OP3_OR   = 6'h02;
    localparam op3_t OP3_XOR  = 6'h03;
    localparam op3_t OP3_SUB  = 6'h04;
    localparam op3_t OP3_ANDN = 6'h05;
    localparam op3_t OP3_ORN  = 6'h06;
    localparam op3_t OP3_XNOR = 6'h07;
    localparam op3_t OP3_ADDX = 6'h08;
    localparam op3_t OP3_SUBX = 6'h0C;
    localparam op3_t OP3_SLL  = 6'h25;
    localparam op3_t OP3_SRL  = 6'h26;
    localparam op3_t OP3_SRA  = 6'h27;

    // operand-read side information captured with an accepted beat
    typedef struct packed {
        logic fwd;   // operand written by the instruction ahead, take bypass data
        logic live;  // register holds a written value (nonzero index, valid)
    } opnd_sel_t;

endpackage

// File: rtl/core/ialu_ram.sv
module ialu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/integer_alu_instruction_execute_unit.sv
// a result beat is offered from the output register after its instruction has passed stage 1 (execute)
// throughput: one instruction per cycle unless stalled, set by the single execute
//   stage and one register file write port; a dependent instruction may follow at once
// reset: aresetn (synchronous, active low) empties both stages and clears the
//   per-register valid bits, so every register reads as zero; no clearing pass
module integer_alu_instruction_execute_unit
    import ialu_pkg::*;
#(
    parameter int unsigned NUM_REGS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instruction,
    input  logic        s_carry_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_enable,
    output logic [4:0]  m_dest_index,
    output logic [31:0] m_write_value,
    output logic        m_illegal
);

    localparam int unsigned IDX_W = $clog2(NUM_REGS);

    // ------------------------------------------------------------------
    // handshake and stage control
    // ------------------------------------------------------------------
    logic s_accept;
    logic s1_advance;
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;

    // stage 1 (execute) frees up when the output register can take its result
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // decode of the incoming beat (register file read addresses)
    // ------------------------------------------------------------------
    reg_idx_t in_rs1;
    reg_idx_t in_rs2;

    assign in_rs1 = s_instruction[18:14];
    assign in_rs2 = s_instruction[4:0];

    // ------------------------------------------------------------------
    // register file: two copies share the write port, one per read operand;
    // valid bits give the all-zero reset without touching the memory
    // ------------------------------------------------------------------
    logic                 rf_wr_en;
    logic [IDX_W-1:0]     rf_wr_addr;
    word_t                rf_wr_data;
    word_t                rf_rd_a;
    word_t                rf_rd_b;
    logic [NUM_REGS-1:0]  rf_valid_reg, rf_valid_next;

    ialu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_REGS)
    ) u_rf_a (
        .aclk    (aclk),
        .wr_en   (rf_wr_en),
        .wr_addr (rf_wr_addr),
        .wr_data (rf_wr_data),
        .rd_en   (s_accept),
        .rd_addr (in_rs1[IDX_W-1:0]),
        .rd_data (rf_rd_a)
    );

    ialu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_REGS)
    ) u_rf_b (
        .aclk    (aclk),
        .wr_en   (rf_wr_en),
        .wr_addr (rf_wr_addr),
        .wr_data (rf_wr_data),
        .rd_en   (s_accept),
        .rd_addr (in_rs2[IDX_W-1:0]),
        .rd_data (rf_rd_b)
    );

    always_comb begin
        rf_valid_next = rf_valid_reg;
        if (rf_wr_en) begin
            rf_valid_next[rf_wr_addr] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stage 1 registers
    // ------------------------------------------------------------------
    word_t      s1_instr_reg;
    logic       s1_carry_reg;
    opnd_sel_t  s1_sel_a_reg, s1_sel_a_next;
    opnd_sel_t  s1_sel_b_reg, s1_sel_b_next;
    word_t      s1_fwd_data_reg;

    // the write retiring in the accept cycle lands after the memory read,
    // so that one write is caught here and bypassed
    always_comb begin
        s1_sel_a_next.fwd  = rf_wr_en && (rf_wr_addr == in_rs1[IDX_W-1:0]);
        s1_sel_a_next.live = (in_rs1 != '0) && rf_valid_reg[in_rs1[IDX_W-1:0]];
        s1_sel_b_next.fwd  = rf_wr_en && (rf_wr_addr == in_rs2[IDX_W-1:0]);
        s1_sel_b_next.live = (in_rs2 != '0) && rf_valid_reg[in_rs2[IDX_W-1:0]];
    end

    always_comb begin
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // execute
    // ------------------------------------------------------------------
    op_t      ex_op;
    reg_idx_t ex_rd;
    op3_t     ex_op3;
    logic     ex_ibit;
    word_t    ex_a;
    word_t    ex_b;
    word_t    ex_simm;
    logic [SHAMT_W-1:0] ex_sh;
    word_t    ex_cy;
    word_t    ex_value;
    logic     ex_ok;

    assign ex_op   = s1_instr_reg[31:30];
    assign ex_rd   = s1_instr_reg[29:25];
    assign ex_op3  = s1_instr_reg[24:19];
    assign ex_ibit = s1_instr_reg[13];
    assign ex_simm = {{(WORD_W-SIMM_W){s1_instr_reg[SIMM_W-1]}}, s1_instr_reg[SIMM_W-1:0]};
    assign ex_cy   = {{(WORD_W-1){1'b0}}, s1_carry_reg};

    // operand a: bypass first, then the stored word, else zero
    always_comb begin
        if (s1_sel_a_reg.fwd) begin
            ex_a = s1_fwd_data_reg;
        end else if (s1_sel_a_reg.live) begin
            ex_a = rf_rd_a;
        end else begin
            ex_a = '0;
        end
    end

    always_comb begin
        if (ex_ibit) begin
            ex_b = ex_simm;
        end else if (s1_sel_b_reg.fwd) begin
            ex_b = s1_fwd_data_reg;
        end else if (s1_sel_b_reg.live) begin
            ex_b = rf_rd_b;
        end else begin
            ex_b = '0;
        end
    end

    assign ex_sh = ex_b[SHAMT_W-1:0];

    always_comb begin
        ex_value = '0;
        ex_ok    = 1'b1;
        unique case (ex_op)
            OP_SETHI: begin
                ex_value = {s1_instr_reg[IMM22_W-1:0], {(WORD_W-IMM22_W){1'b0}}};
            end
            OP_ARITH: begin
                unique case (ex_op3)
                    OP3_ADD:  ex_value = ex_a + ex_b;
                    OP3_AND:  ex_value = ex_a & ex_b;
                    OP3_OR:   ex_value = ex_a | ex_b;
                    OP3_XOR:  ex_value = ex_a ^ ex_b;
                    OP3_SUB:  ex_value = ex_a - ex_b;
                    OP3_ANDN: ex_value = ex_a & ~ex_b;
                    OP3_ORN:  ex_value = ex_a | ~ex_b;
                    OP3_XNOR: ex_value = ~(ex_a ^ ex_b);
                    OP3_ADDX: ex_value = ex_a + ex_b + ex_cy;
                    OP3_SUBX: ex_value = ex_a - ex_b - ex_cy;
                    OP3_SLL:  ex_value = ex_a << ex_sh;
                    OP3_SRL:  ex_value = ex_a >> ex_sh;
                    OP3_SRA:  ex_value = word_t'($signed(ex_a) >>> ex_sh);
                    default:  ex_ok    = 1'b0;
                endcase
            end
            default: ex_ok = 1'b0;
        endcase
        if (!ex_ok) begin
            ex_value = '0;
        end
    end

    // retire: register 0 takes no write but still reports one
    assign rf_wr_en   = s1_advance && ex_ok && (ex_rd != '0);
    assign rf_wr_addr = ex_rd[IDX_W-1:0];
    assign rf_wr_data = ex_value;

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic     m_write_enable_reg;
    reg_idx_t m_dest_index_reg;
    word_t    m_write_value_reg;
    logic     m_illegal_reg;

    always_comb begin
        if (s1_advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            rf_valid_reg <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            rf_valid_reg <= rf_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_instr_reg    <= s_instruction;
            s1_carry_reg    <= s_carry_in;
            s1_sel_a_reg    <= s1_sel_a_next;
            s1_sel_b_reg    <= s1_sel_b_next;
            s1_fwd_data_reg <= rf_wr_data;
        end
        if (s1_advance) begin
            m_write_enable_reg <= ex_ok;
            m_dest_index_reg   <= ex_rd;
            m_write_value_reg  <= ex_value;
            m_illegal_reg      <= !ex_ok;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = m_write_enable_reg;
    assign m_dest_index   = m_dest_index_reg;
    assign m_write_value  = m_write_value_reg;
    assign m_illegal      = m_illegal_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // input back-pressure only comes from a full execute stage behind a stalled output
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    // an illegal result never reports a write and carries a zero value
    a_illegal_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_illegal_reg) |-> (!m_write_enable_reg && (m_write_value_reg == '0)))
        else $error("illegal result reports a write");

    // every register file write shows up as a valid result beat in the next cycle
    a_write_matches_result: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_wr_en |=> (m_valid_reg && m_write_enable_reg && (m_dest_index_reg != '0)))
        else $error("register write without matching result beat");

endmodule
